[rtl/core/tfqdn_pkg.sv]
// Shared constants, types and rule matcher for the label encoder.
package tfqdn_pkg;
  localparam int WinDepth = 16;
  localparam int FillW = 5;
  localparam int IdxW = 4;

  localparam logic [7:0] ChQ = 8'h51;
  localparam logic [7:0] ChZ = 8'h5A;
  localparam logic [7:0] ChDot = 8'h76;
  localparam logic [7:0] ChColon = 8'h6A;

  typedef logic [7:0] byte_t;
  typedef byte_t [WinDepth-1:0] win_t;

  typedef struct packed {
    logic       two;
    byte_t      c0;
    byte_t      c1;
    logic [4:0] used;
  } rule_t;

  typedef struct packed {
    logic load;
    logic run;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
  } dp_sts_t;

  function automatic logic m(win_t w, logic [FillW-1:0] f, int off, string s);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < s.len(); i++) begin
      if (off + i >= f || off + i >= WinDepth) ok = 1'b0;
      else if (w[off+i] != byte_t'(s[i])) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic av(logic [FillW-1:0] f, int k);
    return (k < f) && (k < WinDepth);
  endfunction

  function automatic rule_t q(byte_t code, int used);
    rule_t r;
    r.two = 1'b1;
    r.c0 = ChQ;
    r.c1 = code;
    r.used = 5'(used);
    return r;
  endfunction

  function automatic rule_t z(byte_t code);
    rule_t r;
    r.two = 1'b1;
    r.c0 = ChZ;
    r.c1 = code;
    r.used = 5'd1;
    return r;
  endfunction

  function automatic rule_t p1(byte_t c);
    rule_t r;
    r.two = 1'b0;
    r.c0 = c;
    r.c1 = c;
    r.used = 5'd1;
    return r;
  endfunction

  function automatic rule_t apply_rule(win_t w, logic [FillW-1:0] f);
    rule_t r;
    byte_t c;
    c = w[0];
    r = p1(c);
    case (c)
      ".": begin
        if (av(f, 3) && m(w, f, 1, "mcc")) r = q("m", 4);
        else if (av(f, 7) && m(w, f, 1, "5gc.mnc")) r = q("5", 8);
        else if (av(f, 15) && m(w, f, 1, "3gppnetwork.org")) r = q("3", 16);
        else r = p1(ChDot);
      end
      ":": r = p1(ChColon);
      "a": begin
        if (av(f, 2) && m(w, f, 1, "mf")) r = q("a", 3);
        else if (av(f, 3) && m(w, f, 1, "usf")) r = q("9", 4);
      end
      "b": if (av(f, 2) && m(w, f, 1, "sf")) r = q("b", 3);
      "d": if (av(f, 2) && m(w, f, 1, "ra")) r = q("r", 3);
      "h": begin
        if (av(f, 2) && m(w, f, 1, "ss")) r = q("l", 3);
        else if (av(f, 6) && m(w, f, 1, "ttp")) begin
          if (av(f, 7) && m(w, f, 4, "s://")) r = q("s", 8);
          else if (m(w, f, 4, "://")) r = q("h", 7);
        end
      end
      "i": if (av(f, 5) && m(w, f, 1, "pups")) r = q("i", 5);
      "j": r = z("j");
      "m": if (av(f, 2) && m(w, f, 1, "me")) r = q("o", 3);
      "n": begin
        if (av(f, 2) && m(w, f, 1, "ef")) r = q("8", 3);
        else if (av(f, 2) && m(w, f, 1, "rf")) r = q("n", 3);
        else if (av(f, 3) && m(w, f, 1, "ssf")) r = q("k", 4);
      end
      "p": begin
        if (av(f, 2) && m(w, f, 1, "c")) begin
          if (av(f, 3) && m(w, f, 2, "rf")) r = q("1", 4);
          else if (m(w, f, 2, "f")) r = q("p", 3);
        end else if (av(f, 2) && m(w, f, 1, "gw")) r = q("t", 3);
      end
      "q": r = z("q");
      "s": begin
        if (av(f, 2) && m(w, f, 1, "cp")) r = q("w", 3);
        else if (av(f, 3) && m(w, f, 1, "e")) begin
          if (m(w, f, 2, "cf")) r = q("d", 4);
          else if (m(w, f, 2, "pp")) r = q("e", 4);
        end else if (av(f, 2) && m(w, f, 1, "gw")) r = q("g", 3);
        else if (av(f, 2) && m(w, f, 1, "m")) begin
          if (av(f, 3) && m(w, f, 2, "sf")) r = q("x", 4);
          else if (m(w, f, 2, "f")) r = q("f", 3);
        end
      end
      "u": begin
        if (av(f, 2) && m(w, f, 1, "d")) begin
          if (m(w, f, 2, "m")) r = q("u", 3);
          else if (m(w, f, 2, "r")) r = q("y", 3);
          else if (av(f, 3) && m(w, f, 2, "sf")) r = q("z", 4);
        end else if (av(f, 2) && m(w, f, 1, "pf")) r = q("0", 3);
      end
      "v": r = z("v");
      "z": r = z("z");
      "%": r = z("a");
      "_": r = z("b");
      "!": r = z("c");
      "$": r = z("d");
      "'": r = z("e");
      "(": r = z("f");
      ")": r = z("g");
      "*": r = z("h");
      ",": r = z("i");
      ";": r = z("k");
      "=": r = z("l");
      "[": r = z("m");
      "]": r = z("n");
      "/": r = z("o");
      default: r = p1(c);
    endcase
    if (r.used > 5'(f)) r.used = 5'(f);
    return r;
  endfunction
endpackage

[rtl/core/tfqdn_datapath.sv]
// Lookahead window, rule match register and shift logic.
module tfqdn_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  tfqdn_pkg::dp_cmd_t     cmd,
  input  logic [7:0]             in_byte,
  output tfqdn_pkg::dp_sts_t     sts,
  output tfqdn_pkg::rule_t       rule
);
  tfqdn_pkg::win_t win;
  logic [tfqdn_pkg::FillW-1:0] fill;
  logic [7:0] folded;

  assign folded = (in_byte >= "A" && in_byte <= "Z") ? in_byte + 8'd32 : in_byte;
  assign sts.fill = fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.clear) begin
      fill <= '0;
    end else if (cmd.load) begin
      if (fill < tfqdn_pkg::FillW'(tfqdn_pkg::WinDepth)) begin
        win[fill[tfqdn_pkg::IdxW-1:0]] <= folded;
        fill <= fill + 1'b1;
      end
    end else if (cmd.run) begin
      // shift out consumed bytes
      for (int i = 0; i < tfqdn_pkg::WinDepth; i++)
        if (i + int'(rule.used) < tfqdn_pkg::WinDepth)
          win[i] <= win[i + int'(rule.used)];
      fill <= fill - rule.used;
    end
  end

  // register the match so the window compare stands alone in its path
  always_ff @(posedge clk) rule <= tfqdn_pkg::apply_rule(win, fill);
endmodule

[rtl/core/tfqdn_ctrl.sv]
// Sequencer: load, match, emit one or two characters, drain.
module tfqdn_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic               out_last,
  output tfqdn_pkg::dp_cmd_t cmd,
  input  tfqdn_pkg::dp_sts_t sts,
  input  tfqdn_pkg::rule_t   rule
);
  localparam logic [2:0] S_IDLE = 3'd0, S_EVAL = 3'd1, S_MATCH = 3'd2,
                         S_EMIT0 = 3'd3, S_EMIT1 = 3'd4;
  logic [2:0] state;
  logic drain;
  logic [7:0] hold_c1;
  logic hold_two;
  logic in_xfer, out_xfer;

  assign in_stall = (state != S_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;
  assign out_valid = (state == S_EMIT0) || (state == S_EMIT1);

  always_comb begin
    cmd = '0;
    cmd.load = in_xfer;
    cmd.run = (state == S_MATCH);
  end

  // last flag: final char when draining and window empties after it
  always_comb begin
    out_last = 1'b0;
    if (drain && sts.fill == '0)
      out_last = (state == S_EMIT1) || (state == S_EMIT0 && !hold_two);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      drain <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_xfer) begin
          drain <= in_last;
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (drain ? sts.fill != '0
                    : sts.fill >= tfqdn_pkg::FillW'(tfqdn_pkg::WinDepth))
            state <= S_MATCH;
          else begin
            drain <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_MATCH: begin
          out_char <= rule.c0;
          hold_c1 <= rule.c1;
          hold_two <= rule.two;
          state <= S_EMIT0;
        end
        S_EMIT0: if (out_xfer) begin
          if (hold_two) begin
            out_char <= hold_c1;
            state <= S_EMIT1;
          end else state <= drain ? S_EVAL : S_IDLE;
        end
        S_EMIT1: if (out_xfer) state <= drain ? S_EVAL : S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/tfqdn_label_encoder_unit.sv]
// Top level of the host-name label encoder.
// Takes one name byte per transfer, folds letters to lower case and encodes
// from a 16-byte lookahead window. An input byte is taken, then the window is
// checked and a matching rule registered, and each output character is held
// while the output stalls; the next byte is taken only after any output for
// it is done. On a last byte the window is drained rule by rule before the
// next byte is taken. The rule match over the window is registered.
module tfqdn_label_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_last
);
  tfqdn_pkg::dp_cmd_t cmd;
  tfqdn_pkg::dp_sts_t sts;
  tfqdn_pkg::rule_t   rule;

  tfqdn_datapath u_dp (.clk, .rst, .cmd, .in_byte, .sts, .rule);
  tfqdn_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .in_last, .out_valid,
    .out_stall, .out_char, .out_last, .cmd, .sts, .rule);
endmodule

[rtl/core/tfqdn_checker.sv]
// Port-level checks for the label encoder.
module tfqdn_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] out_char,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output changed");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while output pending");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("output without match cycle");
endmodule

bind tfqdn_label_encoder_unit tfqdn_checker u_chk (.clk, .rst, .in_valid, .in_stall,
  .out_char, .out_valid, .out_stall, .out_last);
